/* src/cdo_pkg.sv */
// Shared types, constants and the month table of the civil date offset unit.
// Used by cdo_days_from, cdo_civil_from and civil_date_offset_unit_core.
`timescale 1ns / 1ps
`default_nettype none

package cdo_pkg;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_DATE = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;

	localparam logic [26:0] DATE_MIN = 27'd10000000;
	localparam logic [26:0] DATE_MAX = 27'd99999999;

	localparam logic [27:0] REC_10K  = 28'd219902326;
	localparam logic [14:0] REC_100  = 15'd20972;
	localparam logic [12:0] REC_25   = 13'd5243;
	localparam logic [23:0] REC_ERA  = 24'd15051803;
	localparam logic [23:0] REC_7    = 24'd9586981;
	localparam logic [18:0] REC_1460 = 19'd367720;
	localparam logic [18:0] REC_365  = 19'd367720;
	localparam logic [11:0] REC_153  = 12'd3427;

	localparam logic [13:0] DEC_10K   = 14'd10000;
	localparam logic [17:0] ERA_DAYS  = 18'd146097;
	localparam logic [17:0] ERA_LAST  = 18'd146096;
	localparam logic [17:0] CENT_DAYS = 18'd36524;
	// Five eras are added ahead of the epoch shift so the day index stays positive.
	localparam logic [23:0] EPOCH_BIAS = 24'd730485;
	localparam logic [22:0] DAY_BIAS   = 23'd1449953;
	localparam logic [15:0] ERA_YEARS  = 16'd2000;
	localparam logic [15:0] YEAR_LOW   = 16'd1000;
	localparam logic [15:0] YEAR_HIGH  = 16'd9999;

	typedef struct packed {
		logic        valid;
		logic        ok;
		logic [22:0] zz;
	} cdo_days_t;

	// First day of each month within a March-based year.
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/cdo_days_from.sv */
// Front half of the pipeline: splits the decimal date, checks it, and forms
// the biased day index with the offset added. Depends on cdo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdo_days_from (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_valid,
	input  logic [26:0]             date_in,
	input  logic signed [20:0]      day_offset,
	output cdo_pkg::cdo_days_t      days_out
);
	import cdo_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [26:0] raw_s1;
	logic [20:0] off_s1, off_s2, off_s3, off_s4, off_s5;
	logic        fmt_s1, fmt_s2, fmt_s3;
	logic [13:0] yr_s1, yr_s2, yr_s3;
	logic [13:0] rem_s2, rem_s3;
	logic [6:0]  mo_s3;
	logic [6:0]  dy_s4;
	logic        ok_s4, ok_s5, ok_s6;
	logic [13:0] yy_s4, yy_s5;
	logic [3:0]  mp_s4;
	logic [21:0] t365_s5;
	logic [7:0]  q100_s5;
	logic [5:0]  q400_s5;
	logic [8:0]  doy_s5;
	logic [22:0] zz_s6;

	logic [54:0] prod_10k;
	logic [26:0] rem_full;
	logic [28:0] prod_100;
	logic [13:0] dy_full;
	logic [6:0]  dy_c;
	logic        early_c;
	logic        ok_c;
	logic [24:0] prod_q100;
	logic [22:0] prod_q400;
	logic [23:0] sum_c;

	always_comb begin
		prod_10k  = 55'(date_in) * 55'(REC_10K);
		rem_full  = raw_s1 - 27'(yr_s1) * 27'(DEC_10K);
		prod_100  = 29'(rem_s2) * 29'(REC_100);
		dy_full   = rem_s3 - 14'(mo_s3) * 14'd100;
		dy_c      = dy_full[6:0];
		early_c   = (mo_s3 <= 7'd2);
		ok_c      = fmt_s3 && (mo_s3 >= 7'd1) && (mo_s3 <= 7'd12)
			&& (dy_c >= 7'd1) && (dy_c <= 7'd31);
		prod_q100 = 25'(yy_s4[13:2]) * 25'(REC_25);
		prod_q400 = 23'(yy_s4[13:4]) * 23'(REC_25);
		sum_c     = 24'(t365_s5) + 24'(yy_s5[13:2]) - 24'(q100_s5) + 24'(q400_s5)
			+ 24'(doy_s5) + {{3{off_s5[20]}}, off_s5} + EPOCH_BIAS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			raw_s1  <= date_in;
			off_s1  <= day_offset;
			fmt_s1  <= (date_in >= DATE_MIN) && (date_in <= DATE_MAX);
			yr_s1   <= prod_10k[54:41];

			off_s2  <= off_s1;
			fmt_s2  <= fmt_s1;
			yr_s2   <= yr_s1;
			rem_s2  <= rem_full[13:0];

			off_s3  <= off_s2;
			fmt_s3  <= fmt_s2;
			yr_s3   <= yr_s2;
			rem_s3  <= rem_s2;
			mo_s3   <= prod_100[27:21];

			off_s4  <= off_s3;
			dy_s4   <= dy_c;
			ok_s4   <= ok_c;
			yy_s4   <= yr_s3 - 14'(early_c);
			mp_s4   <= early_c ? 4'(mo_s3 + 7'd9) : 4'(mo_s3 - 7'd3);

			off_s5  <= off_s4;
			ok_s5   <= ok_s4;
			yy_s5   <= yy_s4;
			t365_s5 <= 22'(yy_s4) * 22'd365;
			q100_s5 <= prod_q100[24:17];
			q400_s5 <= prod_q400[22:17];
			doy_s5  <= month_start(mp_s4) + 9'(dy_s4) - 9'd1;

			ok_s6   <= ok_s5;
			zz_s6   <= sum_c[22:0];
		end
	end

	assign days_out = '{valid: v_s6, ok: ok_s6, zz: zz_s6};

endmodule

`default_nettype wire

/* src/cdo_civil_from.sv */
// Back half of the pipeline: turns the biased day index into year, month,
// day and weekday, and registers the result item. Depends on cdo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdo_civil_from (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  cdo_pkg::cdo_days_t      days_in,
	output logic                    out_valid,
	output logic [26:0]             date_out,
	output logic signed [22:0]      day_count,
	output logic [2:0]              day_of_week,
	output logic                    is_workday,
	output logic [1:0]              status
);
	import cdo_pkg::*;

	logic        v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14;
	logic        ok_s7, ok_s8, ok_s9, ok_s10, ok_s11, ok_s12, ok_s13;
	logic [22:0] zz_s7, zz_s8;
	logic [5:0]  era_s7, era_s8, era_s9, era_s10, era_s11, era_s12;
	logic [17:0] doe_s8, doe_s9, doe_s10;
	logic [19:0] wq_s8;
	logic [22:0] cnt_s9, cnt_s10, cnt_s11, cnt_s12, cnt_s13;
	logic [2:0]  wd_s9, wd_s10, wd_s11, wd_s12, wd_s13;
	logic [17:0] t_s9;
	logic [8:0]  yoe_s10, yoe_s11, yoe_s12;
	logic [8:0]  doy_s11, doy_s12;
	logic [3:0]  mp_s12;
	logic [4:0]  rd_s13;
	logic [3:0]  rm_s13;
	logic [13:0] ry_s13;
	logic        inr_s13;

	logic [46:0] prod_era;
	logic [22:0] doe_full;
	logic [22:0] x7_c;
	logic [46:0] prod_wk;
	logic [22:0] wd_full;
	logic [36:0] prod_1460;
	logic [2:0]  cent_c;
	logic [17:0] t_c;
	logic [36:0] prod_365;
	logic [1:0]  yc_c;
	logic [17:0] doy_full;
	logic [10:0] x153_c;
	logic [22:0] prod_153;
	logic [8:0]  rd_full;
	logic        early_c;
	logic [15:0] ry_c;

	always_comb begin
		prod_era  = 47'(days_in.zz) * 47'(REC_ERA);
		doe_full  = zz_s7 - 23'(era_s7) * 23'(ERA_DAYS);
		x7_c      = zz_s7 + 23'd3;
		prod_wk   = 47'(x7_c) * 47'(REC_7);
		wd_full   = (zz_s8 + 23'd3) - 23'(wq_s8) * 23'd7;
		prod_1460 = 37'(doe_s8) * 37'(REC_1460);
		cent_c    = 3'(doe_s8 >= CENT_DAYS) + 3'(doe_s8 >= 18'd73048)
			+ 3'(doe_s8 >= 18'd109572) + 3'(doe_s8 >= ERA_LAST);
		t_c       = doe_s8 - 18'(prod_1460[35:29]) + 18'(cent_c)
			- 18'(doe_s8 == ERA_LAST);
		prod_365  = 37'(t_s9) * 37'(REC_365);
		yc_c      = 2'(yoe_s10 >= 9'd100) + 2'(yoe_s10 >= 9'd200) + 2'(yoe_s10 >= 9'd300);
		doy_full  = doe_s10 - (18'(yoe_s10) * 18'd365 + 18'(yoe_s10[8:2]) - 18'(yc_c));
		x153_c    = 11'(doy_s11) * 11'd5 + 11'd2;
		prod_153  = 23'(x153_c) * 23'(REC_153);
		rd_full   = doy_s12 - month_start(mp_s12) + 9'd1;
		early_c   = (mp_s12 >= 4'd10);
		ry_c      = 16'(yoe_s12) + 16'(era_s12) * 16'd400 - ERA_YEARS + 16'(early_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
		end else if (adv) begin
			v_s7  <= days_in.valid;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s7   <= days_in.ok;
			zz_s7   <= days_in.zz;
			era_s7  <= prod_era[46:41];

			ok_s8   <= ok_s7;
			zz_s8   <= zz_s7;
			era_s8  <= era_s7;
			doe_s8  <= doe_full[17:0];
			wq_s8   <= prod_wk[45:26];

			ok_s9   <= ok_s8;
			era_s9  <= era_s8;
			doe_s9  <= doe_s8;
			cnt_s9  <= zz_s8 - DAY_BIAS;
			wd_s9   <= wd_full[2:0];
			t_s9    <= t_c;

			ok_s10  <= ok_s9;
			era_s10 <= era_s9;
			doe_s10 <= doe_s9;
			cnt_s10 <= cnt_s9;
			wd_s10  <= wd_s9;
			yoe_s10 <= prod_365[35:27];

			ok_s11  <= ok_s10;
			era_s11 <= era_s10;
			cnt_s11 <= cnt_s10;
			wd_s11  <= wd_s10;
			yoe_s11 <= yoe_s10;
			doy_s11 <= doy_full[8:0];

			ok_s12  <= ok_s11;
			era_s12 <= era_s11;
			cnt_s12 <= cnt_s11;
			wd_s12  <= wd_s11;
			yoe_s12 <= yoe_s11;
			doy_s12 <= doy_s11;
			mp_s12  <= prod_153[22:19];

			ok_s13  <= ok_s12;
			cnt_s13 <= cnt_s12;
			wd_s13  <= wd_s12;
			rd_s13  <= rd_full[4:0];
			rm_s13  <= early_c ? 4'(mp_s12 - 4'd9) : 4'(mp_s12 + 4'd3);
			ry_s13  <= ry_c[13:0];
			inr_s13 <= ($signed(ry_c) >= $signed(YEAR_LOW))
				&& ($signed(ry_c) <= $signed(YEAR_HIGH));

			if (!ok_s13) begin
				date_out    <= '0;
				day_count   <= '0;
				day_of_week <= '0;
				is_workday  <= 1'b0;
				status      <= ST_BAD_DATE;
			end else begin
				date_out    <= inr_s13 ? (27'(ry_s13) * 27'(DEC_10K) + 27'(rm_s13) * 27'd100
					+ 27'(rd_s13)) : '0;
				day_count   <= cnt_s13;
				day_of_week <= wd_s13;
				is_workday  <= (wd_s13 != 3'd0) && (wd_s13 != 3'd6);
				status      <= inr_s13 ? ST_OK : ST_RANGE;
			end
		end
	end

	assign out_valid = v_s14;

endmodule

`default_nettype wire

/* src/civil_date_offset_unit_core.sv */
// Top level of the civil date offset unit: handshake control around the
// two pipeline halves. Depends on cdo_pkg, cdo_days_from and cdo_civil_from.
`timescale 1ns / 1ps
`default_nettype none

// The unit adds a signed day offset to an eight-digit YYYYMMDD date and
// returns the new date, its day count since 1970-01-01, its weekday and a
// workday flag. It is a fourteen-stage pipeline that accepts one item every
// cycle while the output is not held and registers each result in its last
// stage; the chain of constant-reciprocal multiplies that splits the date and
// the day count sets that depth. When the output is held the whole pipeline
// holds, and in_ready follows out_ready while the last stage is full.
module civil_date_offset_unit_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [26:0]         date_in,
	input  logic signed [20:0]  day_offset,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [26:0]         date_out,
	output logic signed [22:0]  day_count,
	output logic [2:0]          day_of_week,
	output logic                is_workday,
	output logic [1:0]          status
);
	import cdo_pkg::*;

	logic      adv;
	cdo_days_t days_mid;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	cdo_days_from u_days (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (in_valid),
		.date_in    (date_in),
		.day_offset (day_offset),
		.days_out   (days_mid)
	);

	cdo_civil_from u_civil (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.days_in     (days_mid),
		.out_valid   (out_valid),
		.date_out    (date_out),
		.day_count   (day_count),
		.day_of_week (day_of_week),
		.is_workday  (is_workday),
		.status      (status)
	);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_BAD_DATE || status == ST_RANGE))
		else $error("status code out of range");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BAD_DATE |-> date_out == '0 && day_count == '0
			&& day_of_week == '0 && !is_workday)
		else $error("invalid-date item carries nonzero fields");

	a_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> day_of_week <= 3'd6
			&& is_workday == (day_of_week != 3'd0 && day_of_week != 3'd6))
		else $error("weekday or workday flag inconsistent");

	a_date_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> date_out >= DATE_MIN && date_out <= 27'd99991231)
		else $error("good item has a date outside years 1000 to 9999");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_RANGE |-> date_out == '0)
		else $error("out-of-range item carries a date");

endmodule

`default_nettype wire
